/* rtl/gcac_pkg.sv */
`timescale 1ns / 1ps

package gcac_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_TDATA_W = 56;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_MODE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PUMP_MODE       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FAN_MODE        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WATER_PERIOD_MS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WATER_FLOW_MS   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HUMIDITY = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_ON_BELOW  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_OFF_ABOVE = 3'd7;

  // light uses opposite encoding to pump and fan
  localparam logic [1:0] LIGHT_FORCE_OFF = 2'd1;
  localparam logic [1:0] LIGHT_FORCE_ON  = 2'd2;
  localparam logic [1:0] DRIVE_FORCE_ON  = 2'd1;
  localparam logic [1:0] DRIVE_FORCE_OFF = 2'd2;

  localparam logic [7:0] HUM_BAND = 8'd10;

  localparam logic [31:0] RST_WATER_PERIOD_MS = 32'd3600000;
  localparam logic [31:0] RST_WATER_FLOW_MS   = 32'd60000;
  localparam logic [6:0]  RST_TARGET_HUMIDITY = 7'd60;
  localparam logic [9:0]  RST_LIGHT_ON_BELOW  = 10'd400;
  localparam logic [9:0]  RST_LIGHT_OFF_ABOVE = 10'd700;
  localparam logic [31:0] RST_PUMP_LAST       = 32'd4294867296;

endpackage

/* rtl/grow_chamber_actuator_control.sv */
`timescale 1ns / 1ps

// grow chamber actuator control
// input stream: one word per sensor tick, in_tdata = time_ms [31:0],
//   light_level [41:32], humidity [48:42], upper bits zero
// output stream: one word per tick, out_tdata = lamp_on [0], pump_on [1],
//   fan_on [2], humidifier_toggle [3], humidifier_active [4]
// config: cfg_we writes cfg_wdata to register cfg_addr (0 light_mode,
//   1 pump_mode, 2 fan_mode, 3 water_period_ms, 4 water_flow_ms,
//   5 target_humidity, 6 light_on_below, 7 light_off_above); write only
//   while no word is in flight
// throughput: one word per cycle while out_tready is high; an input register and a result register
//   with compare/subtract logic between them
// the controller state (lamp, pump timer, humidifier) updates when a word
//   moves into the result register
// reset: registers take their default values, pump timer starts at -100000
// stall: while out_tready is low the result holds and one more input word
//   is taken into the input register if it is empty, then in_tready drops
module grow_chamber_actuator_control (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gcac_pkg::IN_TDATA_W-1:0]    in_tdata,   // time_ms, light_level, humidity
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gcac_pkg::OUT_TDATA_W-1:0]   out_tdata,  // lamp_on, pump_on, fan_on,
                                                         // humidifier_toggle, humidifier_active
  input  logic                               cfg_we,
  input  logic [gcac_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gcac_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gcac_pkg::*;

  logic [1:0]  light_mode_r, pump_mode_r, fan_mode_r;
  logic [31:0] water_period_r, water_flow_r;
  logic [6:0]  target_hum_r;
  logic [9:0]  on_below_r, off_above_r;

  logic        in_valid_r;
  logic [31:0] time_r;
  logic [9:0]  level_r;
  logic [6:0]  hum_r;

  logic        out_valid_r;
  logic [4:0]  res_r;

  logic        lamp_state_r, lamp_state_nxt;
  logic        pump_state_r, pump_state_nxt;
  logic [31:0] pump_last_r, pump_last_nxt;
  logic        hmd_state_r, hmd_state_nxt;
  logic [4:0]  res_nxt;

  logic        load;
  logic        lamp_out, pump_out, fan_out, toggle;
  logic [31:0] elapsed;
  logic [7:0]  hum_ext, tgt_ext;
  logic        hum_low;

  assign load      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || load;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_mode_r   <= 2'd0;
      pump_mode_r    <= 2'd0;
      fan_mode_r     <= 2'd0;
      water_period_r <= RST_WATER_PERIOD_MS;
      water_flow_r   <= RST_WATER_FLOW_MS;
      target_hum_r   <= RST_TARGET_HUMIDITY;
      on_below_r     <= RST_LIGHT_ON_BELOW;
      off_above_r    <= RST_LIGHT_OFF_ABOVE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LIGHT_MODE:      light_mode_r   <= cfg_wdata[1:0];
        REG_PUMP_MODE:       pump_mode_r    <= cfg_wdata[1:0];
        REG_FAN_MODE:        fan_mode_r     <= cfg_wdata[1:0];
        REG_WATER_PERIOD_MS: water_period_r <= cfg_wdata[31:0];
        REG_WATER_FLOW_MS:   water_flow_r   <= cfg_wdata[31:0];
        REG_TARGET_HUMIDITY: target_hum_r   <= cfg_wdata[6:0];
        REG_LIGHT_ON_BELOW:  on_below_r     <= cfg_wdata[9:0];
        REG_LIGHT_OFF_ABOVE: off_above_r    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      time_r  <= in_tdata[31:0];
      level_r <= in_tdata[41:32];
      hum_r   <= in_tdata[48:42];
    end
  end

  always_comb begin
    lamp_state_nxt = lamp_state_r;
    pump_state_nxt = pump_state_r;
    pump_last_nxt  = pump_last_r;
    elapsed        = time_r - pump_last_r;

    case (light_mode_r)
      LIGHT_FORCE_OFF: lamp_out = 1'b0;
      LIGHT_FORCE_ON:  lamp_out = 1'b1;
      default: begin
        if (level_r > off_above_r) begin
          lamp_state_nxt = 1'b0;
        end else if (level_r < on_below_r) begin
          lamp_state_nxt = 1'b1;
        end
        lamp_out = lamp_state_nxt;
      end
    endcase

    case (pump_mode_r)
      DRIVE_FORCE_ON:  pump_out = 1'b1;
      DRIVE_FORCE_OFF: pump_out = 1'b0;
      default: begin
        if (!pump_state_r && elapsed >= water_period_r) begin
          pump_state_nxt = 1'b1;
          pump_last_nxt  = time_r;
        end else if (pump_state_r && elapsed >= water_flow_r) begin
          pump_state_nxt = 1'b0;
          pump_last_nxt  = time_r;
        end
        pump_out = pump_state_nxt;
      end
    endcase

    hum_ext = {1'b0, hum_r};
    tgt_ext = {1'b0, target_hum_r};

    case (fan_mode_r)
      DRIVE_FORCE_ON:  fan_out = 1'b1;
      DRIVE_FORCE_OFF: fan_out = 1'b0;
      default:         fan_out = hum_ext > (tgt_ext + HUM_BAND);
    endcase

    // humidity below target - 10, never true for a setpoint under 10
    hum_low       = (hum_ext + HUM_BAND) < tgt_ext;
    hmd_state_nxt = hum_low;
    toggle        = hum_low != hmd_state_r;

    res_nxt = {hmd_state_nxt, toggle, fan_out, pump_out, lamp_out};
  end

  // result register and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      lamp_state_r <= 1'b0;
      pump_state_r <= 1'b0;
      pump_last_r  <= RST_PUMP_LAST;
      hmd_state_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r  <= 1'b1;
        lamp_state_r <= lamp_state_nxt;
        pump_state_r <= pump_state_nxt;
        pump_last_r  <= pump_last_nxt;
        hmd_state_r  <= hmd_state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  a_toggle_marks_change: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (res_r[3] == ($past(hmd_state_r) != hmd_state_r)))
    else $error("humidifier toggle does not match state change");

  a_pump_timer_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (pump_mode_r == DRIVE_FORCE_ON || pump_mode_r == DRIVE_FORCE_OFF))
    |=> ($stable(pump_last_r) && $stable(pump_state_r)))
    else $error("pump timer moved while pump forced");

  a_lamp_forced_off: assert property (@(posedge clk) disable iff (!rst_n)
    (load && light_mode_r == LIGHT_FORCE_OFF) |=> !res_r[0])
    else $error("lamp on while forced off");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
